>>> hdl/gradient_palette_entry_macros.svh
// Assertion macros for the gradient palette entry block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef GRADIENT_PALETTE_ENTRY_MACROS_SVH
`define GRADIENT_PALETTE_ENTRY_MACROS_SVH

// same-cycle implication
`define GPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/gpe_pkg.sv
// Shared types and constants of the gradient palette entry block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package gpe_pkg;

  localparam int ROM_GRADIENTS     = 13;
  localparam int ROM_STOPS         = 13;
  localparam int MAX_STOPS_DEF     = 13;
  localparam int PALETTE_COUNT_DEF = 13;

  localparam int PAL_W      = 4;   // palette select width
  localparam int IBITS_W    = 5;   // index_bits width
  localparam int IDX_W      = 16;  // entry index and stop offset width
  localparam int ROM_STOP_W = 4;   // stop address width in the ROM
  localparam int CNT_W      = 5;   // stop count, up to 16
  localparam int CH_W       = 8;
  localparam int LANES      = 3;   // red, green, blue
  localparam int DEN_W      = IDX_W + 1;            // 2*n
  localparam int NUM_W      = IDX_W + CH_W + 1;     // 2*m*d + n
  localparam int QUO_W      = CH_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS = 2'd1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_DEGEN = 2'd2
  } status_e;

  // lane 2 red, lane 1 green, lane 0 blue (matches 24'hRRGGBB)
  typedef logic [LANES-1:0][CH_W-1:0] rgb_t;

  typedef struct packed {
    logic [IDX_W-1:0] off;
    rgb_t             rgb;
  } stop_t;

  typedef struct packed {
    logic                        valid;
    logic [DEN_W-1:0]            den;
    logic [LANES-1:0][NUM_W-1:0] num;
  } div_req_t;

  typedef struct packed {
    logic                        done;
    logic [LANES-1:0][QUO_W-1:0] quo;
  } div_rsp_t;

  localparam logic [ROM_STOP_W-1:0] STOP_COUNT [ROM_GRADIENTS] =
    '{4'd7, 4'd9, 4'd2, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8, 4'd9, 4'd7, 4'd6, 4'd10, 4'd13};

endpackage

`default_nettype wire

>>> hdl/gpe_stop_rom.sv
// Gradient stop ROM: offset and RGB of each stop, one registered read per cycle.
// Depends on gpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpe_stop_rom import gpe_pkg::*; (
  input  logic                  clk_i,
  input  logic [PAL_W-1:0]      pal_i,
  input  logic [ROM_STOP_W-1:0] stop_i,
  output stop_t                 data_o
);

  localparam logic [IDX_W-1:0] STOP_OFF [ROM_GRADIENTS][ROM_STOPS] = '{
    '{0, 10260, 21040, 32891, 43865, 60032, 65535, 0, 0, 0, 0, 0, 0},
    '{0, 4308, 12933, 22058, 30828, 43661, 53070, 56709, 65535, 0, 0, 0, 0},
    '{0, 65535, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 1506, 32431, 41122, 49189, 65237, 65535, 0, 0, 0, 0, 0, 0},
    '{0, 1506, 22179, 29516, 44285, 50570, 65237, 65535, 0, 0, 0, 0, 0},
    '{0, 1506, 22179, 29516, 44285, 50570, 65237, 65535, 0, 0, 0, 0, 0},
    '{0, 1506, 11933, 30650, 47146, 56705, 65237, 65535, 0, 0, 0, 0, 0},
    '{0, 1506, 6950, 30650, 47146, 56705, 65237, 65535, 0, 0, 0, 0, 0},
    '{0, 1506, 4713, 10768, 23321, 39105, 57443, 65237, 65535, 0, 0, 0, 0},
    '{0, 3957, 20330, 24440, 41268, 45002, 65535, 0, 0, 0, 0, 0, 0},
    '{0, 8192, 16652, 33006, 48110, 65535, 0, 0, 0, 0, 0, 0, 0},
    '{0, 1938, 18382, 28542, 35837, 42575, 52725, 55191, 65237, 65535, 0, 0, 0},
    '{0, 4170, 8056, 10916, 13583, 18365, 25515, 33006, 37917, 44588, 49014, 53615,
      65535}
  };

  localparam rgb_t STOP_RGB [ROM_GRADIENTS][ROM_STOPS] = '{
    '{24'h000000, 24'h5f0060, 24'h0000f7, 24'h00f700, 24'hf80000, 24'hf8f80c,
      24'hffffff, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{24'h000000, 24'h520052, 24'h0000a3, 24'h00a8a5, 24'h05a800, 24'hfca600,
      24'hfc2c00, 24'hfcfc00, 24'hffffff, 24'h0, 24'h0, 24'h0, 24'h0},
    '{24'h000000, 24'hffffff, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
      24'h0, 24'h0, 24'h0, 24'h0},
    '{24'h000000, 24'h080000, 24'hfc0000, 24'hfc8000, 24'hfcf900, 24'hfcfcf7,
      24'hffffff, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{24'h000000, 24'h0c0000, 24'hc00000, 24'hfc4400, 24'hfcc82d, 24'hfcfc6c,
      24'hfcfcf9, 24'hffffff, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{24'h000000, 24'h0c0000, 24'hbc1800, 24'he85000, 24'hfcc444, 24'hfcec6c,
      24'hfcfcfc, 24'hffffff, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{24'h000000, 24'h080016, 24'h3f008b, 24'hab0800, 24'hfca41f, 24'hfcf070,
      24'hfcfcf8, 24'hffffff, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{24'h000000, 24'h08001b, 24'h24006b, 24'hbd1a00, 24'hfcac26, 24'hfcf072,
      24'hfcfcf0, 24'hffffff, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{24'h000000, 24'h040656, 24'h230f72, 24'h6208a0, 24'hbf278d, 24'hf8801e,
      24'hf8e24f, 24'heaf7f0, 24'hffffff, 24'h0, 24'h0, 24'h0, 24'h0},
    '{24'h000000, 24'h64005c, 24'h0000eb, 24'h005be0, 24'h07b000, 24'hb8bc00,
      24'hdc0000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{24'h000000, 24'h710076, 24'h0000f8, 24'h02f900, 24'hfcf200, 24'hfc0000,
      24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{24'h05064c, 24'h040656, 24'h0377db, 24'h85c10e, 24'he6d007, 24'hf7bc0f,
      24'hf91b43, 24'hf74064, 24'hfcddc9, 24'hffffff, 24'h0, 24'h0, 24'h0},
    '{24'h000000, 24'h550049, 24'h740080, 24'h67009c, 24'h3d00b0, 24'h001ebc,
      24'h0078a3, 24'h00bc4b, 24'h16d600, 24'ha2e200, 24'hdfe000, 24'hfcbc00,
      24'hfc0000}
  };

  stop_t data_q;

  always_ff @(posedge clk_i) begin
    if (pal_i < PAL_W'(ROM_GRADIENTS) && stop_i < ROM_STOP_W'(ROM_STOPS)) begin
      data_q.off <= STOP_OFF[pal_i][stop_i];
      data_q.rgb <= STOP_RGB[pal_i][stop_i];
    end else begin
      data_q <= '0;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

>>> hdl/gpe_divider.sv
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
// Quotient is known to fit in QUO_W bits. Depends on gpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpe_divider import gpe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int STEP_W = $clog2(QUO_W);

  logic [LANES-1:0][NUM_W-1:0] rem_q, rem_d;
  logic [LANES-1:0][QUO_W-1:0] quo_q, quo_d;
  logic [NUM_W-2:0]            dsh_q, dsh_d;   // divisor aligned to current bit
  logic [STEP_W-1:0]           step_q, step_d;
  logic                        run_q, run_d;
  logic                        done_q, done_d;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsh_d  = dsh_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.valid) begin
      rem_d  = req_i.num;
      quo_d  = '0;
      dsh_d  = {req_i.den, (QUO_W-1)'(0)};
      step_d = STEP_W'(QUO_W - 1);
      run_d  = 1'b1;
    end else if (run_q) begin
      for (int l = 0; l < LANES; l++) begin
        if (rem_q[l] >= {1'b0, dsh_q}) begin
          rem_d[l] = rem_q[l] - {1'b0, dsh_q};
          quo_d[l] = {quo_q[l][QUO_W-2:0], 1'b1};
        end else begin
          quo_d[l] = {quo_q[l][QUO_W-2:0], 1'b0};
        end
      end
      dsh_d  = dsh_q >> 1;
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsh_q <= dsh_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

>>> hdl/gradient_palette_entry.sv
// Gradient palette entry: RGB of one table entry from a built-in gradient.
// A flagged item is answered straight from idle; otherwise the stop scan reads the
// ROM (one read per cycle) and ends on a degenerate interval or hands a colour
// to the 8-step divider. One item at a time; the next start is taken in the cycle
// its strobe shows. Reset: palette_select 0, index_bits 8, idle; no clear pass.
`timescale 1ns / 1ps
`default_nettype none
`include "gradient_palette_entry_macros.svh"

module gradient_palette_entry import gpe_pkg::*; #(
  parameter int MAX_STOPS     = MAX_STOPS_DEF,
  parameter int PALETTE_COUNT = PALETTE_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [IDX_W-1:0]      entry_index_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output logic [IDX_W-1:0]      entry_echo_o,
  output logic [CH_W-1:0]       red_o,
  output logic [CH_W-1:0]       green_o,
  output logic [CH_W-1:0]       blue_o,
  output logic [1:0]            status_o
);

  localparam int STOP_W = $clog2(MAX_STOPS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FIRST = 5'b00010,
    S_SCAN  = 5'b00100,
    S_MUL   = 5'b01000,
    S_DIV   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [PAL_W-1:0]   palette_q;
  logic [IBITS_W-1:0] index_bits_q;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [STOP_W-1:0] k_q, k_d;
  logic [STOP_W-1:0] last_q, last_d;
  logic [IDX_W-1:0]  b_q, b_d;        // shifted offset of the previous stop
  rgb_t              c0_q, c0_d;      // colour of the previous stop
  rgb_t              c1_q, c1_d;
  logic [IDX_W-1:0]  n_q, n_d, m_q, m_d;
  rgb_t              base_q, base_d;

  logic              done_q, done_d;
  logic [IDX_W-1:0]  echo_q, echo_d;
  rgb_t              rgb_q, rgb_d;
  status_e           status_q, status_d;

  stop_t     rom_data;
  logic [ROM_STOP_W-1:0] rd_stop;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  logic                  bits_bad, pal_bad, idx_bad, start_ok;
  logic [CNT_W-1:0]      cnt_c;
  logic [IBITS_W-1:0]    sh;
  logic [IDX_W-1:0]      cur_off;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_q    <= '0;
      index_bits_q <= IBITS_W'(8);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PALETTE:    palette_q    <= cfg_data_i[PAL_W-1:0];
        CFG_INDEX_BITS: index_bits_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item checks
  always_comb begin
    bits_bad = (index_bits_q < IBITS_W'(2)) || (index_bits_q > IBITS_W'(16));
    pal_bad  = ({1'b0, palette_q} >= (PAL_W+1)'(PALETTE_COUNT)) ||
               ({1'b0, palette_q} >= (PAL_W+1)'(ROM_GRADIENTS));
    idx_bad  = (({1'b0, entry_index_i} >> index_bits_q) != '0);
    cnt_c    = pal_bad ? '0 : CNT_W'(STOP_COUNT[palette_q]);
    if (cnt_c > CNT_W'(MAX_STOPS))
      cnt_c = CNT_W'(MAX_STOPS);
    if (cnt_c > CNT_W'(ROM_STOPS))
      cnt_c = CNT_W'(ROM_STOPS);
    start_ok = start && !busy && !(bits_bad || pal_bad || idx_bad) &&
               (cnt_c >= CNT_W'(2));
    sh       = IBITS_W'(16) - index_bits_q;
    cur_off  = rom_data.off >> sh;
  end

  assign rd_stop = (state_q == S_IDLE) ? '0 : ROM_STOP_W'(k_q + 1'b1);

  gpe_stop_rom u_rom (
    .clk_i  (clk_i),
    .pal_i  (palette_q),
    .stop_i (rd_stop),
    .data_o (rom_data)
  );

  gpe_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    logic [CH_W-1:0]        d;
    logic [IDX_W-1:0]       mm;
    logic [IDX_W+CH_W-1:0]  prod;

    state_d  = state_q;
    idx_d    = idx_q;
    k_d      = k_q;
    last_d   = last_q;
    b_d      = b_q;
    c0_d     = c0_q;
    c1_d     = c1_q;
    n_d      = n_q;
    m_d      = m_q;
    base_d   = base_q;
    done_d   = 1'b0;
    echo_d   = echo_q;
    rgb_d    = rgb_q;
    status_d = status_q;
    div_req  = '0;
    d        = '0;
    mm       = '0;
    prod     = '0;

    case (state_q)
      S_IDLE: begin
        k_d = '0;
        if (start && !busy) begin
          idx_d  = entry_index_i;
          last_d = STOP_W'(cnt_c - 1'b1);
          if (bits_bad || pal_bad || idx_bad) begin
            done_d   = 1'b1;
            echo_d   = entry_index_i;
            rgb_d    = '0;
            status_d = ST_BAD;
          end else if (cnt_c < CNT_W'(2)) begin
            done_d   = 1'b1;
            echo_d   = entry_index_i;
            rgb_d    = '0;
            status_d = ST_DEGEN;
          end else begin
            state_d = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        b_d     = cur_off;
        c0_d    = rom_data.rgb;
        k_d     = k_q + 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (idx_q >= b_q && idx_q <= cur_off) begin
          if (cur_off <= b_q) begin
            done_d   = 1'b1;
            echo_d   = idx_q;
            rgb_d    = '0;
            status_d = ST_DEGEN;
            state_d  = S_IDLE;
          end else begin
            n_d     = cur_off - b_q;
            m_d     = idx_q - b_q;
            c1_d    = rom_data.rgb;
            state_d = S_MUL;
          end
        end else if (k_q == last_q) begin
          // ran out of intervals
          done_d   = 1'b1;
          echo_d   = idx_q;
          rgb_d    = '0;
          status_d = ST_DEGEN;
          state_d  = S_IDLE;
        end else begin
          b_d  = cur_off;
          c0_d = rom_data.rgb;
          k_d  = k_q + 1'b1;
        end
      end
      S_MUL: begin
        div_req.valid = 1'b1;
        div_req.den   = {n_q, 1'b0};
        for (int l = 0; l < LANES; l++) begin
          // interpolate from the lower colour so the rounding stays half-up
          if (c0_q[l] <= c1_q[l]) begin
            base_d[l] = c0_q[l];
            d         = c1_q[l] - c0_q[l];
            mm        = m_q;
          end else begin
            base_d[l] = c1_q[l];
            d         = c0_q[l] - c1_q[l];
            mm        = n_q - m_q;
          end
          prod = mm * d;
          div_req.num[l] = {prod, 1'b0} + NUM_W'(n_q);
        end
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          for (int l = 0; l < LANES; l++)
            rgb_d[l] = base_q[l] + div_rsp.quo[l];
          done_d   = 1'b1;
          echo_d   = idx_q;
          status_d = ST_OK;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    last_q   <= last_d;
    b_q      <= b_d;
    c0_q     <= c0_d;
    c1_q     <= c1_d;
    n_q      <= n_d;
    m_q      <= m_d;
    base_q   <= base_d;
    echo_q   <= echo_d;
    rgb_q    <= rgb_d;
    status_q <= status_d;
  end

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign entry_echo_o = echo_q;
  assign red_o        = rgb_q[2];
  assign green_o      = rgb_q[1];
  assign blue_o       = rgb_q[0];
  assign status_o     = status_q;

  `GPE_ASSERT_NOW(a_done_idle, done_o, !busy, "result strobe while still busy")
  `GPE_ASSERT_NOW(a_err_black, done_o && (status_o != ST_OK),
                  (red_o == '0) && (green_o == '0) && (blue_o == '0),
                  "flagged item carries a nonzero colour")
  `GPE_ASSERT_NEXT(a_start_busy, start_ok, busy, "good item did not start the scan")
  `GPE_ASSERT_NOW(a_div_state, div_rsp.done, state_q == S_DIV,
                  "divider finished outside the divide state")

endmodule

`default_nettype wire
